// File: sv/cgs_pkg.sv
// ============================================================================
// cgs_pkg
// Shared types, register map and reset values for the cadence gear selector.
// ============================================================================
`default_nettype none

package cgs_pkg;

  // Field widths.
  localparam int SampleW = 10;
  localparam int CountW  = 8;
  localparam int GearW   = 4;

  // Configuration port geometry.
  localparam int AddrW = 5;
  localparam int DataW = 32;
  localparam int RegIdxW = 3;

  // Register indexes (byte address is 4 times the index).
  localparam logic [RegIdxW-1:0] REG_LOW_THRESHOLD  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_HIGH_THRESHOLD = 3'd1;
  localparam logic [RegIdxW-1:0] REG_WINDOW_TICKS   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_FAST_LIMIT     = 3'd3;
  localparam logic [RegIdxW-1:0] REG_SLOW_LIMIT     = 3'd4;
  localparam logic [RegIdxW-1:0] REG_MAX_GEAR       = 3'd5;

  // Register reset values.
  localparam logic [SampleW-1:0] LOW_THRESHOLD_RST  = 10'd200;
  localparam logic [SampleW-1:0] HIGH_THRESHOLD_RST = 10'd700;
  localparam logic [CountW-1:0]  WINDOW_TICKS_RST   = 8'd50;
  localparam logic [CountW-1:0]  FAST_LIMIT_RST     = 8'd5;
  localparam logic [CountW-1:0]  SLOW_LIMIT_RST     = 8'd3;
  localparam logic [GearW-1:0]   MAX_GEAR_RST       = 4'd15;

  // Item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Lowest gear and full pass count.
  localparam logic [GearW-1:0]  GEAR_MIN   = 4'd1;
  localparam logic [CountW-1:0] COUNT_FULL = 8'hFF;

  typedef struct packed {
    logic [SampleW-1:0] low_threshold;
    logic [SampleW-1:0] high_threshold;
    logic [CountW-1:0]  window_ticks;
    logic [CountW-1:0]  fast_limit;
    logic [CountW-1:0]  slow_limit;
    logic [GearW-1:0]   max_gear;
  } cfg_t;

  typedef struct packed {
    logic             pass_seen;
    logic             indicator;
    logic             gear_changed;
    logic [GearW-1:0] gear;
  } result_t;

endpackage

`default_nettype wire

// File: sv/cgs_regs.sv
// ============================================================================
// cgs_regs
// Configuration register file behind an APB-style port.
// ============================================================================
`default_nettype none

module cgs_regs
  import cgs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic               wr_en;
  logic [RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[AddrW-1:2];

  // Register writes; writes outside the map are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_threshold  <= LOW_THRESHOLD_RST;
      cfg.high_threshold <= HIGH_THRESHOLD_RST;
      cfg.window_ticks   <= WINDOW_TICKS_RST;
      cfg.fast_limit     <= FAST_LIMIT_RST;
      cfg.slow_limit     <= SLOW_LIMIT_RST;
      cfg.max_gear       <= MAX_GEAR_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LOW_THRESHOLD:  cfg.low_threshold  <= pwdata[SampleW-1:0];
        REG_HIGH_THRESHOLD: cfg.high_threshold <= pwdata[SampleW-1:0];
        REG_WINDOW_TICKS:   cfg.window_ticks   <= pwdata[CountW-1:0];
        REG_FAST_LIMIT:     cfg.fast_limit     <= pwdata[CountW-1:0];
        REG_SLOW_LIMIT:     cfg.slow_limit     <= pwdata[CountW-1:0];
        REG_MAX_GEAR:       cfg.max_gear       <= pwdata[GearW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_LOW_THRESHOLD:  prdata = {{(DataW-SampleW){1'b0}}, cfg.low_threshold};
      REG_HIGH_THRESHOLD: prdata = {{(DataW-SampleW){1'b0}}, cfg.high_threshold};
      REG_WINDOW_TICKS:   prdata = {{(DataW-CountW){1'b0}}, cfg.window_ticks};
      REG_FAST_LIMIT:     prdata = {{(DataW-CountW){1'b0}}, cfg.fast_limit};
      REG_SLOW_LIMIT:     prdata = {{(DataW-CountW){1'b0}}, cfg.slow_limit};
      REG_MAX_GEAR:       prdata = {{(DataW-GearW){1'b0}}, cfg.max_gear};
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/cgs_engine.sv
// ============================================================================
// cgs_engine
// Hysteresis pass detector, tick window counter and gear selection state.
// ============================================================================
`default_nettype none

module cgs_engine
  import cgs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic               kind,
  input  wire logic [SampleW-1:0] sample,
  input  wire cfg_t               cfg,
  output result_t                 result
);

  logic              armed;
  logic              armed_next;
  logic [CountW-1:0] pass_count;
  logic [CountW-1:0] pass_count_next;
  logic [CountW-1:0] tick_count;
  logic [CountW-1:0] tick_count_next;
  logic [GearW-1:0]  current_gear;
  logic [GearW-1:0]  current_gear_next;
  logic              indicator_level;
  logic              indicator_level_next;
  logic [CountW:0]   tick_inc;
  logic              changed;
  logic              seen;

  assign tick_inc = {1'b0, tick_count} + {{CountW{1'b0}}, 1'b1};

  // Next-state logic for one item.
  always_comb begin
    armed_next           = armed;
    pass_count_next      = pass_count;
    tick_count_next      = tick_count;
    current_gear_next    = current_gear;
    indicator_level_next = indicator_level;
    changed              = 1'b0;
    seen                 = 1'b0;
    if (step) begin
      if (kind == KIND_SAMPLE) begin
        if (armed) begin
          // A low reading while armed is one magnet pass.
          if (sample <= cfg.low_threshold) begin
            if (pass_count != COUNT_FULL) begin
              pass_count_next = pass_count + 1'b1;
            end
            armed_next           = 1'b0;
            indicator_level_next = 1'b1;
            seen                 = 1'b1;
          end
        end else if (sample >= cfg.high_threshold) begin
          armed_next           = 1'b1;
          indicator_level_next = 1'b0;
        end
      end else begin
        // Window ends once the incremented count exceeds the window length.
        if (tick_inc > {1'b0, cfg.window_ticks}) begin
          if (pass_count > cfg.fast_limit) begin
            if (current_gear < cfg.max_gear) begin
              current_gear_next = current_gear + 1'b1;
              changed           = 1'b1;
            end
          end else if (pass_count < cfg.slow_limit) begin
            if (current_gear > GEAR_MIN) begin
              current_gear_next = current_gear - 1'b1;
              changed           = 1'b1;
            end
          end
          tick_count_next = '0;
          pass_count_next = '0;
        end else begin
          tick_count_next = tick_inc[CountW-1:0];
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed           <= 1'b1;
      pass_count      <= '0;
      tick_count      <= '0;
      current_gear    <= GEAR_MIN;
      indicator_level <= 1'b1;
    end else begin
      armed           <= armed_next;
      pass_count      <= pass_count_next;
      tick_count      <= tick_count_next;
      current_gear    <= current_gear_next;
      indicator_level <= indicator_level_next;
    end
  end

  assign result.gear         = current_gear_next;
  assign result.gear_changed = changed;
  assign result.indicator    = indicator_level_next;
  assign result.pass_seen    = seen;

  // The gear never drops to zero.
  a_gear_nonzero: assert property (@(posedge clk) disable iff (rst)
    current_gear != '0)
    else $error("gear register reached zero");

  // A counted pass leaves the detector disarmed.
  a_pass_disarms: assert property (@(posedge clk) disable iff (rst)
    step && seen |=> !armed && indicator_level)
    else $error("detector still armed after a pass");

  // A gear change closes the window and clears both counters.
  a_change_clears: assert property (@(posedge clk) disable iff (rst)
    step && changed |=> pass_count == '0 && tick_count == '0)
    else $error("counters not cleared after gear change");

endmodule

`default_nettype wire

// File: sv/cadence_gear_selector_core.sv
// ============================================================================
// cadence_gear_selector_core
// Cadence-based gear selector: input register, update logic, result register.
// ============================================================================
// Accepted items pass through the input register, then the state update
// writes the result register.
// Throughput: one item per cycle while m_tready holds, set by the state update loop.
// Reset (rst, synchronous): detector armed, counters cleared, gear 1,
// indicator high, registers at their reset values, both stages empty.
`default_nettype none

module cadence_gear_selector_core
  import cgs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // Input stream.
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [15:0]      s_tdata,   // [9:0] sample, [15:10] zero
  input  wire logic             s_tuser,   // [0] kind
  // Result stream.
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [7:0]       m_tdata,   // [3:0] gear, [4] gear_changed,
                                           // [5] indicator, [6] pass_seen
  // Configuration port.
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  cfg_t               cfg;
  result_t            result;
  result_t            out_result;
  logic               in_valid;
  logic               in_kind;
  logic [SampleW-1:0] in_sample;
  logic               out_valid;
  logic               out_free;
  logic               step;
  logic               in_accept;

  cgs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the input register drains whenever the result register frees.
  assign out_free  = !out_valid || m_tready;
  assign step      = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;
  assign in_accept = s_tvalid && s_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_accept) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_kind   <= s_tuser;
      in_sample <= s_tdata[SampleW-1:0];
    end
  end

  cgs_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .kind   (in_kind),
    .sample (in_sample),
    .cfg    (cfg),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_result};

  // A blocked item stays in the input register.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_free |=> in_valid && $stable(in_kind) && $stable(in_sample))
    else $error("input item lost while blocked");

  // The result register only fills when an item moves through.
  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !step |=> !out_valid)
    else $error("result appeared without an item");

endmodule

`default_nettype wire
